// ----- rtl/apfp_pkg.sv -----
package apfp_pkg;

	localparam int IdW       = 16;
	localparam int DistW     = 26;
	localparam int OutTdataW = 64;
	localparam int RootW     = 32;
	localparam logic [DistW-1:0] Q8Max = {DistW{1'b1}};
	// drain count at which the best distance is settled and the square root may start
	localparam logic [1:0] DrainLast = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FILL,
		ST_P_START,
		ST_ISSUE,
		ST_DRAIN,
		ST_SQRT_START,
		ST_SQRT,
		ST_OUT
	} apfp_state_t;

	typedef struct packed {
		logic load;
		logic fill;
		logic clr_best;
		logic issue;
		logic first_k;
		logic last_k;
		logic sqrt_start;
		logic rd_ids;
		logic out_load;
		logic last_point;
		logic finish;
	} apfp_cmd_t;

	typedef struct packed {
		logic need_fill;
		logic fill_done;
		logic sqrt_busy;
		logic out_free;
	} apfp_stat_t;

endpackage

// ----- rtl/apfp_sqrt.sv -----
module apfp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [63:0]                   sq_in,
	output logic                          busy,
	output logic [apfp_pkg::DistW-1:0]    root_q8
);

	logic [63:0]                 rad_q;
	logic [apfp_pkg::RootW+1:0]  rem_q;
	logic [apfp_pkg::RootW-1:0]  root_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        sat_q;

	logic [apfp_pkg::RootW+1:0]  rem_sh;
	logic [apfp_pkg::RootW+1:0]  trial;
	logic                        take;

	always_comb begin
		rem_sh = {rem_q[apfp_pkg::RootW-1:0], rad_q[63:62]};
		trial  = {root_q, 2'b01};
		take   = rem_sh >= trial;
	end

	// one result bit per cycle, radicand is the square shifted up by 16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (sq_in[63:48] == '0);
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {sq_in[47:0], 16'b0};
			rem_q  <= '0;
			root_q <= '0;
			sat_q  <= (sq_in[63:48] != '0);
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[apfp_pkg::RootW-2:0], take};
		end
	end

	assign busy    = busy_q;
	assign root_q8 = (sat_q || root_q > apfp_pkg::RootW'(apfp_pkg::Q8Max)) ?
		apfp_pkg::Q8Max : root_q[apfp_pkg::DistW-1:0];

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("sqrt started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && sq_in[63:48] != '0 |=> !busy_q && sat_q)
		else $error("saturated square did not bypass iteration");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 |=> !busy_q)
		else $error("sqrt ran past its last step");

endmodule

// ----- rtl/apfp_datapath.sv -----
module apfp_datapath #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DIMS   = 8,
	parameter int COORD_BITS = 16,
	parameter int PW         = 6,
	parameter int KW         = 3,
	parameter int CNTW       = 7,
	parameter int INW        = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [3:0]                        cfg_wr_data,
	input  logic [INW-1:0]                    s_tdata,
	input  logic                              s_tlast,
	input  apfp_pkg::apfp_cmd_t               cmd,
	input  logic [PW-1:0]                     p_idx,
	input  logic [PW-1:0]                     q_idx,
	input  logic [KW-1:0]                     k_idx,
	output apfp_pkg::apfp_stat_t              stat,
	output logic [CNTW-1:0]                   point_cnt,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [apfp_pkg::OutTdataW-1:0]    m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	localparam int CDEPTH = 2 ** (PW + KW);
	localparam int SW     = 2 * COORD_BITS + $clog2(MAX_DIMS) + 1;
	localparam int BW     = (SW > 64) ? 64 : SW;
	localparam logic [SW-1:0] SatMax = SW'({BW{1'b1}});

	logic signed [COORD_BITS-1:0] coord_mem [CDEPTH];
	logic [apfp_pkg::IdW-1:0]     id_mem [MAX_POINTS];

	logic [3:0]             dims_q;
	logic [CNTW-1:0]        count_q;
	logic [KW-1:0]          pos_q;
	logic                   ovf_q;
	logic [PW-1:0]          fill_row_q;
	logic [KW-1:0]          fill_k_q;

	logic signed [COORD_BITS-1:0] rd_a_s1, rd_b_s1;
	logic                   vld_s1, vld_s2, vld_s3;
	logic                   first_s1, first_s2, first_s3;
	logic                   last_s1, last_s2, last_s3;
	logic [PW-1:0]          q_s1, q_s2, q_s3;
	logic [COORD_BITS-1:0]  absd_s2;
	logic [2*COORD_BITS-1:0] sq_s3;
	logic [SW-1:0]          acc_q;
	logic [BW-1:0]          best_q;
	logic [PW-1:0]          partner_q;

	logic [apfp_pkg::IdW-1:0] src_id_q, far_id_q;
	logic                   out_vld_q;
	logic [apfp_pkg::OutTdataW-1:0] out_data_q;
	logic                   out_user_q, out_last_q;

	logic [apfp_pkg::IdW-1:0]     in_id;
	logic signed [COORD_BITS-1:0] in_coord;
	logic                   have_slot, complete;
	int                     dims_eff;
	logic                   cwe;
	logic [PW+KW-1:0]       cwaddr;
	logic signed [COORD_BITS-1:0] cwdata;
	logic signed [COORD_BITS:0]   diff;
	logic [SW-1:0]          acc_next;
	logic [BW-1:0]          tot;
	logic [apfp_pkg::DistW-1:0] root_dist;
	logic                   sqrt_busy;

	assign in_id    = s_tdata[apfp_pkg::IdW-1:0];
	assign in_coord = s_tdata[apfp_pkg::IdW +: COORD_BITS];

	always_comb begin
		if (dims_q == '0) begin
			dims_eff = 1;
		end else if (int'(dims_q) > MAX_DIMS) begin
			dims_eff = MAX_DIMS;
		end else begin
			dims_eff = int'(dims_q);
		end
		have_slot      = int'(count_q) < MAX_POINTS;
		complete       = s_tlast || (int'(pos_q) + 1 >= dims_eff);
		stat.need_fill = have_slot && complete && (int'(pos_q) + 1 < MAX_DIMS);
		stat.fill_done = fill_k_q == KW'(MAX_DIMS - 1);
		stat.out_free  = !out_vld_q || m_tready;
		stat.sqrt_busy = sqrt_busy;
		cwe    = (cmd.load && have_slot) || cmd.fill;
		cwaddr = cmd.load ? {count_q[PW-1:0], pos_q} : {fill_row_q, fill_k_q};
		cwdata = cmd.load ? in_coord : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= 4'd1;
			count_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dims_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				if (complete) begin
					pos_q <= '0;
					if (have_slot) begin
						count_q <= count_q + CNTW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end else begin
					pos_q <= pos_q + KW'(1);
				end
			end else if (cmd.finish) begin
				count_q <= '0;
				pos_q   <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// zero the unused tail of a completed point
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fill_row_q <= count_q[PW-1:0];
			fill_k_q   <= pos_q + KW'(1);
		end else if (cmd.fill) begin
			fill_k_q <= fill_k_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cwe) begin
			coord_mem[cwaddr] <= cwdata;
		end
		rd_a_s1 <= coord_mem[{p_idx, k_idx}];
		rd_b_s1 <= coord_mem[{q_idx, k_idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && complete && have_slot) begin
			id_mem[count_q[PW-1:0]] <= in_id;
		end
		if (cmd.rd_ids) begin
			src_id_q <= id_mem[p_idx];
			far_id_q <= id_mem[partner_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign diff = COORD_BITS'(rd_a_s1) - COORD_BITS'(rd_b_s1) == '0 ?
		'0 : (COORD_BITS + 1)'(rd_a_s1) - (COORD_BITS + 1)'(rd_b_s1);

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first_k;
		last_s1  <= cmd.last_k;
		q_s1     <= q_idx;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		q_s2     <= q_s1;
		absd_s2  <= diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		q_s3     <= q_s2;
		sq_s3    <= absd_s2 * absd_s2;
	end

	always_comb begin
		acc_next = first_s3 ? SW'(sq_s3) : acc_q + SW'(sq_s3);
		tot      = (acc_next > SatMax) ? '1 : acc_next[BW-1:0];
	end

	// keep the earliest partner on ties
	always_ff @(posedge clk) begin
		if (cmd.clr_best) begin
			best_q    <= '0;
			partner_q <= '0;
		end else if (vld_s3) begin
			acc_q <= acc_next;
			if (last_s3 && tot > best_q) begin
				best_q    <= tot;
				partner_q <= q_s3;
			end
		end
	end

	apfp_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqrt_start),
		.sq_in   (64'(best_q)),
		.busy    (sqrt_busy),
		.root_q8 (root_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= apfp_pkg::OutTdataW'({root_dist, far_id_q, src_id_q});
			out_user_q <= ovf_q;
			out_last_q <= cmd.last_point;
		end
	end

	assign point_cnt = count_q;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign m_tlast   = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) int'(count_q) <= MAX_POINTS)
		else $error("point count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> stat.out_free)
		else $error("result word overwritten");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> !vld_s1 && !vld_s3)
		else $error("load during distance pipeline");

endmodule

// ----- rtl/apfp_ctrl.sv -----
module apfp_ctrl #(
	parameter int MAX_DIMS = 8,
	parameter int PW       = 6,
	parameter int KW       = 3,
	parameter int CNTW     = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	input  apfp_pkg::apfp_stat_t  stat,
	input  logic [CNTW-1:0]       point_cnt,
	output apfp_pkg::apfp_cmd_t   cmd,
	output logic [PW-1:0]         p_idx,
	output logic [PW-1:0]         q_idx,
	output logic [KW-1:0]         k_idx
);

	localparam int QW = CNTW + 1;

	apfp_pkg::apfp_state_t state_q, state_d;
	logic [PW-1:0] p_q, q_q;
	logic [KW-1:0] k_q;
	logic [1:0]    drain_q;
	logic          end_q;

	logic          accept;
	logic          k_last;
	logic          last_point;
	logic [QW-1:0] q_next, q_first;
	logic          q_next_out, q_first_out;

	always_comb begin
		accept      = (state_q == apfp_pkg::ST_LOAD) && s_tvalid;
		k_last      = k_q == KW'(MAX_DIMS - 1);
		last_point  = QW'(p_q) + QW'(1) == QW'(point_cnt);
		q_next      = QW'(q_q) + QW'(1);
		if (q_next == QW'(p_q)) begin
			q_next = QW'(q_q) + QW'(2);
		end
		q_first     = (p_q == '0) ? QW'(1) : QW'(0);
		q_next_out  = q_next >= QW'(point_cnt);
		q_first_out = q_first >= QW'(point_cnt);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apfp_pkg::ST_LOAD: begin
				if (accept) begin
					if (stat.need_fill) begin
						state_d = apfp_pkg::ST_FILL;
					end else if (s_tlast) begin
						state_d = apfp_pkg::ST_P_START;
					end
				end
			end
			apfp_pkg::ST_FILL: begin
				if (stat.fill_done) begin
					state_d = end_q ? apfp_pkg::ST_P_START : apfp_pkg::ST_LOAD;
				end
			end
			apfp_pkg::ST_P_START: begin
				state_d = q_first_out ? apfp_pkg::ST_DRAIN : apfp_pkg::ST_ISSUE;
			end
			apfp_pkg::ST_ISSUE: begin
				if (k_last && q_next_out) begin
					state_d = apfp_pkg::ST_DRAIN;
				end
			end
			apfp_pkg::ST_DRAIN: begin
				if (drain_q == apfp_pkg::DrainLast) begin
					state_d = apfp_pkg::ST_SQRT_START;
				end
			end
			apfp_pkg::ST_SQRT_START: state_d = apfp_pkg::ST_SQRT;
			apfp_pkg::ST_SQRT: begin
				if (!stat.sqrt_busy) begin
					state_d = apfp_pkg::ST_OUT;
				end
			end
			apfp_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_d = last_point ? apfp_pkg::ST_LOAD : apfp_pkg::ST_P_START;
				end
			end
			default: state_d = apfp_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd            = '0;
		s_tready       = 1'b0;
		cmd.first_k    = k_q == '0;
		cmd.last_k     = k_last;
		cmd.last_point = last_point;
		unique case (state_q)
			apfp_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				cmd.load = accept;
			end
			apfp_pkg::ST_FILL:       cmd.fill = 1'b1;
			apfp_pkg::ST_P_START:    cmd.clr_best = 1'b1;
			apfp_pkg::ST_ISSUE:      cmd.issue = 1'b1;
			apfp_pkg::ST_SQRT_START: begin
				cmd.sqrt_start = 1'b1;
				cmd.rd_ids     = 1'b1;
			end
			apfp_pkg::ST_OUT: begin
				cmd.out_load = stat.out_free;
				cmd.finish   = stat.out_free && last_point;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apfp_pkg::ST_LOAD;
			p_q     <= '0;
			q_q     <= '0;
			k_q     <= '0;
			drain_q <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				end_q <= s_tlast;
			end
			unique case (state_q)
				apfp_pkg::ST_P_START: begin
					q_q     <= q_first[PW-1:0];
					k_q     <= '0;
					drain_q <= '0;
				end
				apfp_pkg::ST_ISSUE: begin
					k_q <= k_q + KW'(1);
					if (k_last) begin
						k_q <= '0;
						q_q <= q_next[PW-1:0];
					end
				end
				apfp_pkg::ST_DRAIN: drain_q <= drain_q + 2'd1;
				apfp_pkg::ST_OUT: begin
					if (stat.out_free) begin
						p_q <= last_point ? '0 : p_q + PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign p_idx = p_q;
	assign q_idx = q_q;
	assign k_idx = k_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apfp_pkg::ST_ISSUE |-> q_q != p_q && QW'(q_q) < QW'(point_cnt))
		else $error("pair issued against itself or beyond the cluster");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != apfp_pkg::ST_LOAD |-> !s_tready)
		else $error("input taken during search");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == apfp_pkg::ST_LOAD && p_q == '0)
		else $error("cluster did not close");

endmodule

// ----- rtl/all_pairs_farthest_point.sv -----
// Farthest point search within one cluster. Feed coordinates one word at a
// time (point_id in s_tdata[15:0], coordinate in the bits above, s_tlast on
// the last coordinate of the cluster); cfg_wr_data sets coordinates per
// point. Each completed point with fewer than MAX_DIMS coordinates has its
// tail zeroed after its last word. After s_tlast, each point is compared
// with every other: one coordinate pair is read from the single coordinate
// memory per cycle, then a bit-serial square root runs. Results leave in
// load order, one per point, with m_tlast on the final one and m_tuser set
// when points past MAX_POINTS were dropped.
module all_pairs_farthest_point #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DIMS   = 8,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// point_id, coordinate, zero fill
	input  logic [((16 + COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// source_id, farthest_id, distance_q8, zero fill
	output logic [63:0] m_tdata,
	// dropped
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int PW   = $clog2(MAX_POINTS);
	localparam int KW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int INW  = ((16 + COORD_BITS + 7) / 8) * 8;

	apfp_pkg::apfp_cmd_t  cmd;
	apfp_pkg::apfp_stat_t stat;
	logic [PW-1:0]   p_idx, q_idx;
	logic [KW-1:0]   k_idx;
	logic [CNTW-1:0] point_cnt;

	apfp_ctrl #(
		.MAX_DIMS (MAX_DIMS),
		.PW       (PW),
		.KW       (KW),
		.CNTW     (CNTW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.s_tready  (s_tready),
		.stat      (stat),
		.point_cnt (point_cnt),
		.cmd       (cmd),
		.p_idx     (p_idx),
		.q_idx     (q_idx),
		.k_idx     (k_idx)
	);

	apfp_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_DIMS   (MAX_DIMS),
		.COORD_BITS (COORD_BITS),
		.PW         (PW),
		.KW         (KW),
		.CNTW       (CNTW),
		.INW        (INW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.cmd         (cmd),
		.p_idx       (p_idx),
		.q_idx       (q_idx),
		.k_idx       (k_idx),
		.stat        (stat),
		.point_cnt   (point_cnt),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 64;
	localparam int NDIM = 8;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [15:0]                src;
		logic [15:0]                far;
		logic [apfp_pkg::DistW-1:0] dist_q8;
		logic                       drop;
		logic                       last;
	} far_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [3:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	all_pairs_farthest_point u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// predictor state
	longint      pt_coord [NPTS][NDIM];
	logic [15:0] pt_id [NPTS];
	int          n_pts;
	int          coord_pos;
	bit          drop_flag;
	logic [3:0]  dims_reg;

	far_result_t pending_far[$];
	int          n_errors;
	int          n_results;
	int          n_clusters;
	int          n_words;
	longint      cycles;
	int          burst_left;
	int          hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d results still due", $time, pending_far.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pair_sq(input int a, input int b);
		longint unsigned sum;
		longint d;
		sum = 0;
		for (int k = 0; k < NDIM; k++) begin
			d = pt_coord[a][k] - pt_coord[b][k];
			if (d < 0)
				d = -d;
			sum += d * d;
		end
		return sum;
	endfunction

	// update the cluster model with one accepted word; on cluster end queue results
	function automatic void predict_farthest(input logic [15:0] id, input logic [15:0] crd,
			input bit last);
		int dims;
		longint unsigned best;
		longint unsigned d;
		longint unsigned q8;
		int partner;
		far_result_t r;
		dims = (dims_reg == 0) ? 1 : (dims_reg > NDIM) ? NDIM : dims_reg;
		if (n_pts < NPTS)
			pt_coord[n_pts][coord_pos] = longint'($signed(crd));
		if (last || coord_pos + 1 >= dims) begin
			if (n_pts < NPTS) begin
				for (int k = coord_pos + 1; k < NDIM; k++)
					pt_coord[n_pts][k] = 0;
				pt_id[n_pts] = id;
				n_pts++;
			end else begin
				drop_flag = 1'b1;
			end
			coord_pos = 0;
		end else begin
			coord_pos++;
		end
		if (!last)
			return;
		for (int p = 0; p < n_pts; p++) begin
			best = 0;
			partner = 0;
			for (int q = 0; q < n_pts; q++) begin
				if (q != p) begin
					d = pair_sq(p, q);
					if (d > best) begin
						best = d;
						partner = q;
					end
				end
			end
			q8 = (best >= (64'd1 << 48)) ? apfp_pkg::Q8Max : int_sqrt(best << 16);
			if (q8 > apfp_pkg::Q8Max)
				q8 = apfp_pkg::Q8Max;
			r.src = pt_id[p];
			r.far = pt_id[partner];
			r.dist_q8 = q8[apfp_pkg::DistW-1:0];
			r.drop = drop_flag;
			r.last = (p + 1 == n_pts);
			pending_far.insert(pending_far.size(), r);
		end
		n_clusters++;
		n_pts = 0;
		coord_pos = 0;
		drop_flag = 1'b0;
	endfunction

	// result checker: a word is taken at the next rising edge when both are high here
	always @(negedge clk) begin
		far_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_far.size() == 0) begin
				$display("%0t: unexpected result, got %h user %b last %b", $time, m_tdata,
					m_tuser, m_tlast);
				n_errors++;
			end else begin
				e = pending_far.pop_front();
				if (m_tdata[15:0] !== e.src) begin
					$display("%0t: source_id expected %h actual %h", $time, e.src, m_tdata[15:0]);
					n_errors++;
				end
				if (m_tdata[31:16] !== e.far) begin
					$display("%0t: farthest_id expected %h actual %h", $time, e.far,
						m_tdata[31:16]);
					n_errors++;
				end
				if (m_tdata[32+:apfp_pkg::DistW] !== e.dist_q8) begin
					$display("%0t: distance_q8 expected %h actual %h", $time, e.dist_q8,
						m_tdata[32+:apfp_pkg::DistW]);
					n_errors++;
				end
				if (m_tuser !== e.drop) begin
					$display("%0t: dropped expected %b actual %b", $time, e.drop, m_tuser);
					n_errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last_result expected %b actual %b", $time, e.last, m_tlast);
					n_errors++;
				end
			end
		end
	end

	// receiver: long hold on request, otherwise a stall pattern picked from bits 8:6 of the cycle counter
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
			m_tready <= 1'b0;
		end else begin
			case (cycles[8:6] % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(1, 0);
				2: m_tready <= ($urandom_range(3, 0) == 0);
				default: m_tready <= ($urandom_range(7, 0) != 0);
			endcase
		end
	end

	// offer one word, in bursts with random gaps; returns at the accepting edge
	task automatic send_word(input logic [15:0] id, input logic [15:0] crd, input bit last);
		bit rdy;
		if (burst_left == 0) begin
			burst_left = $urandom_range(10, 1);
			if ($urandom_range(2, 0) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {crd, id};
		s_tlast <= last;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		n_words++;
		predict_farthest(id, crd, last);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(7, 0))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(15, 0));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_cluster(input int npts, input int dims);
		for (int p = 0; p < npts; p++)
			for (int k = 0; k < dims; k++)
				send_word(16'($urandom()), pick_coord(), (p == npts - 1) && (k == dims - 1));
	endtask

	// drain all results, then let the block settle before touching the register
	task automatic settle();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (pending_far.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_dims(input logic [3:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dims_reg = v;
		@(posedge clk);
	endtask

	task automatic test_directed();
		write_dims(4'd1);
		send_word(16'hffff, 16'h1234, 1'b1);
		send_word(16'h0000, 16'h8000, 1'b0);
		send_word(16'hffff, 16'h7fff, 1'b1);
		settle();
		// zero register behaves as one; equal points and a repeated index
		write_dims(4'd0);
		send_word(16'h0011, 16'h0005, 1'b0);
		send_word(16'h0011, 16'h0005, 1'b0);
		send_word(16'h0022, 16'h0005, 1'b1);
		settle();
		// above the maximum behaves as eight; full-range spread, then a tie
		write_dims(4'd15);
		for (int k = 0; k < NDIM; k++)
			send_word(16'haaaa, 16'h8000, 1'b0);
		for (int k = 0; k < NDIM; k++)
			send_word(16'h5555, 16'h7fff, k == NDIM - 1);
		settle();
		write_dims(4'd8);
		for (int k = 0; k < NDIM; k++)
			send_word(16'h0001, 16'h0000, 1'b0);
		for (int k = 0; k < NDIM; k++)
			send_word(16'h0002, (k == 0) ? 16'h0003 : 16'h0000, 1'b0);
		for (int k = 0; k < NDIM; k++)
			send_word(16'h0003, (k == 1) ? 16'hfffd : 16'h0000, k == NDIM - 1);
		settle();
		// cluster end before the point is complete
		write_dims(4'd3);
		send_word(16'h0100, 16'h0010, 1'b0);
		send_word(16'h0100, 16'h0020, 1'b0);
		send_word(16'h0100, 16'h0030, 1'b0);
		send_word(16'h0200, 16'hfff0, 1'b1);
		settle();
	endtask

	task automatic test_capacity();
		write_dims(4'd1);
		for (int i = 0; i < NPTS + 2; i++)
			send_word(16'($urandom()), pick_coord(), i == NPTS + 1);
		settle();
	endtask

	task automatic test_random();
		int dims;
		int sent;
		int npts;
		for (int ph = 0; ph < 4; ph++) begin
			dims = (ph == 0) ? 2 : (ph == 1) ? 5 : (ph == 2) ? 8 : 4;
			write_dims(4'(dims));
			sent = 0;
			while (sent < 6) begin
				npts = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 7) : $urandom_range(4, 1);
				if ($urandom_range(5, 0) == 0) begin
					// short final point
					send_cluster(npts - 1, dims);
					send_word(16'($urandom()), pick_coord(), 1'b1);
					sent += (npts - 1) * dims + 1;
				end else begin
					send_cluster(npts, dims);
					sent += npts * dims;
				end
			end
			settle();
		end
	endtask

	task automatic test_backpressure();
		write_dims(4'd2);
		hold_req = 3000;
		for (int c = 0; c < 4; c++)
			send_cluster($urandom_range(3, 2), 2);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 4'd0;
		s_tvalid = 1'b0;
		s_tdata = 32'd0;
		s_tlast = 1'b0;
		cycles = 0;
		n_errors = 0;
		n_results = 0;
		n_clusters = 0;
		n_words = 0;
		burst_left = 0;
		hold_req = 0;
		n_pts = 0;
		coord_pos = 0;
		drop_flag = 1'b0;
		dims_reg = 4'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_capacity();
		test_random();
		test_backpressure();
		$display("sent %0d words in %0d clusters, checked %0d results", n_words, n_clusters,
			n_results);
		$display("covered dimension settings 0,1,2,3,4,5,8,15, overflow and long output stall");
		if (n_errors == 0 && pending_far.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- all_pairs_farthest_point.f -----
rtl/apfp_pkg.sv
rtl/apfp_sqrt.sv
rtl/apfp_datapath.sv
rtl/apfp_ctrl.sv
rtl/all_pairs_farthest_point.sv
verif/tb_top.sv
